// ===== rtl/cc_pkg.sv =====
// Shared types, constants and the quarter-round function of the ChaCha20 cipher.
// No dependencies.
package cc_pkg;

  localparam int unsigned ROUNDS = 20;
  localparam int unsigned QDEPTH = 4;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef enum logic [2:0] {
    CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3, CFG_NONCE_LO, CFG_NONCE_HI
  } cfg_idx_t;

  typedef struct packed {
    logic [255:0] key;
    logic [95:0]  nonce;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [5:0]  pos;
    logic        newblk;
    logic [31:0] ctr;
  } q_entry_t;

  typedef enum logic {BK_IDLE, BK_RUN} bk_state_t;

  function automatic logic [127:0] qr(input logic [31:0] a, b, c, d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b;   td = d ^ ta; td = {td[15:0], td[31:16]};
    tc = c + td;  tb = b ^ tc; tb = {tb[19:0], tb[31:20]};
    ta = ta + tb; td = td ^ ta; td = {td[23:0], td[31:24]};
    tc = tc + td; tb = tb ^ tc; tb = {tb[24:0], tb[31:25]};
    return {ta, tb, tc, td};
  endfunction

endpackage

// ===== rtl/cc_if.sv =====
// Valid/ready stream interfaces for input bytes and result bytes.
// Depends on nothing.
interface cc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, data_byte, last, input ready);
  modport sink (input valid, data_byte, last, output ready);
endinterface

interface cc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink (input valid, out_byte, out_last, output ready);
endinterface

// ===== rtl/chacha20_stream_cipher.sv =====
// ChaCha20 byte stream cipher top level: configuration registers, front end, queue, back end.
// A byte that opens a block first waits for the block core to make its keystream
// (one round per cycle over 20 rounds, after loading the initial state).
// Throughput: one byte per cycle within a block while the output side accepts bytes.
// Synchronous active-low reset clears control state and key/nonce registers to zero.
// Depends on cc_pkg, cc_if, cc_front, cc_fifo and cc_back.
module chacha20_stream_cipher import cc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  cc_in_if.sink       in_ch,
  cc_out_if.source    out_ch
);
  cfg_t     cfg_r;
  q_entry_t wr_entry, head;
  logic     push, pop, head_valid, full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY0:     cfg_r.key[63:0]    <= cfg_data;
        CFG_KEY1:     cfg_r.key[127:64]  <= cfg_data;
        CFG_KEY2:     cfg_r.key[191:128] <= cfg_data;
        CFG_KEY3:     cfg_r.key[255:192] <= cfg_data;
        CFG_NONCE_LO: cfg_r.nonce[63:0]  <= cfg_data;
        CFG_NONCE_HI: cfg_r.nonce[95:64] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .q_full(full), .push(push), .entry(wr_entry)
  );

  cc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_entry(wr_entry), .pop(pop),
    .head(head), .head_valid(head_valid), .full(full)
  );

  cc_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(head), .head_valid(head_valid),
    .pop(pop), .out_if(out_ch)
  );
endmodule

// ===== rtl/cc_front.sv =====
// Front end: takes input transfers, tracks byte position and block counter.
// Depends on cc_pkg and cc_in_if.
module cc_front import cc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  cc_in_if.sink    in_if,
  input  logic     q_full,
  output logic     push,
  output q_entry_t entry
);
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] ctr_r, ctr_nxt;

  assign in_if.ready = !q_full;
  assign push = in_if.valid && in_if.ready;

  always_comb begin
    entry.data   = in_if.data_byte;
    entry.last   = in_if.last;
    entry.pos    = pos_r;
    entry.newblk = (pos_r == 6'd0);
    entry.ctr    = ctr_r;
    pos_nxt = pos_r;
    ctr_nxt = ctr_r;
    if (push) begin
      if (in_if.last) begin
        pos_nxt = '0;
        ctr_nxt = '0;
      end else begin
        pos_nxt = pos_r + 6'd1;
        ctr_nxt = ctr_r + {31'd0, entry.newblk};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ctr_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ctr_r <= ctr_nxt;
    end
  end
endmodule

// ===== rtl/cc_fifo.sv =====
// Short queue between front and back end.
// Depends on cc_pkg.
module cc_fifo import cc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_entry,
  input  logic     pop,
  output q_entry_t head,
  output logic     head_valid,
  output logic     full
);
  localparam int unsigned AW = $clog2(QDEPTH);
  q_entry_t       mem_r [QDEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign head       = mem_r[rp_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == (AW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> !pop) else $error("queue underflow");
endmodule

// ===== rtl/cc_back.sv =====
// Back end: ChaCha20 block core (one round per cycle), keystream store, XOR, output register.
// Depends on cc_pkg and cc_out_if.
module cc_back import cc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  q_entry_t head,
  input  logic     head_valid,
  output logic     pop,
  cc_out_if.source out_if
);
  bk_state_t   st_r, st_nxt;
  logic [4:0]  rnd_r;
  logic [31:0] work_r [16];
  logic [31:0] ks_r [16];
  logic [31:0] init_w [16];
  logic [31:0] rnd_w [16];
  logic        blk_ready_r;
  logic        ov_r;
  logic [7:0]  ob_r;
  logic        ol_r;
  logic        start, fin, out_free;
  logic [31:0] ks_word;

  always_comb begin
    init_w[0] = SIGMA0; init_w[1] = SIGMA1; init_w[2] = SIGMA2; init_w[3] = SIGMA3;
    for (int i = 0; i < 8; i++) init_w[4+i] = cfg.key[32*i +: 32];
    init_w[12] = head.ctr;
    for (int i = 0; i < 3; i++) init_w[13+i] = cfg.nonce[32*i +: 32];
  end

  always_comb begin
    if (!rnd_r[0]) begin
      for (int i = 0; i < 4; i++)
        {rnd_w[i], rnd_w[4+i], rnd_w[8+i], rnd_w[12+i]} =
          qr(work_r[i], work_r[4+i], work_r[8+i], work_r[12+i]);
    end else begin
      {rnd_w[0], rnd_w[5], rnd_w[10], rnd_w[15]} =
        qr(work_r[0], work_r[5], work_r[10], work_r[15]);
      {rnd_w[1], rnd_w[6], rnd_w[11], rnd_w[12]} =
        qr(work_r[1], work_r[6], work_r[11], work_r[12]);
      {rnd_w[2], rnd_w[7], rnd_w[8], rnd_w[13]} =
        qr(work_r[2], work_r[7], work_r[8], work_r[13]);
      {rnd_w[3], rnd_w[4], rnd_w[9], rnd_w[14]} =
        qr(work_r[3], work_r[4], work_r[9], work_r[14]);
    end
  end

  assign out_free = !ov_r || out_if.ready;
  assign fin      = (st_r == BK_RUN) && (rnd_r == 5'(ROUNDS - 1));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (head_valid && head.newblk && !blk_ready_r) st_nxt = BK_RUN;
      BK_RUN:  if (fin) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    start = 1'b0;
    pop   = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        start = head_valid && head.newblk && !blk_ready_r;
        pop   = head_valid && (!head.newblk || blk_ready_r) && out_free;
      end
      BK_RUN: ;
      default: ;
    endcase
  end

  assign ks_word = ks_r[head.pos[5:2]];
  assign out_if.valid    = ov_r;
  assign out_if.out_byte = ob_r;
  assign out_if.out_last = ol_r;

  always_ff @(posedge clk) begin
    if (start) work_r <= init_w;
    else if (st_r == BK_RUN) work_r <= rnd_w;
    if (fin) begin
      for (int i = 0; i < 16; i++) ks_r[i] <= rnd_w[i] + init_w[i];
    end
    if (pop) begin
      ob_r <= head.data ^ ks_word[{head.pos[1:0], 3'b000} +: 8];
      ol_r <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      rnd_r       <= '0;
      blk_ready_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (start) rnd_r <= '0;
      else if (st_r == BK_RUN) rnd_r <= rnd_r + 5'd1;
      if (fin) blk_ready_r <= 1'b1;
      else if (pop && head.newblk) blk_ready_r <= 1'b0;
      if (pop) ov_r <= 1'b1;
      else if (out_if.ready) ov_r <= 1'b0;
    end
  end

  a_newblk_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.newblk) |-> blk_ready_r) else $error("byte used before block made");
  a_no_pop_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_RUN) |-> !pop) else $error("pop while core runs");
  a_fin_ready: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> blk_ready_r) else $error("block not flagged ready");
endmodule
